// File: rtl/core/tua_pkg.sv
package tua_pkg;

    // Default depth of the raw byte store
    localparam int unsigned STORE_BYTES_DEF = 65536;

    // Width of a computed source pixel index (covers 1023 * 2047 + 1023)
    localparam int unsigned SRC_W = 23;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_PIXEL_MODE   = 3'd0;
    localparam logic [2:0] REG_SWIZZLED     = 3'd1;
    localparam logic [2:0] REG_HALF_WIDTH   = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;

    // Item opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Pixel modes
    localparam logic MODE_8BIT = 1'b0;
    localparam logic MODE_4BIT = 1'b1;

    // Read sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_ADDR = 4'b0100,
        S_DATA = 4'b1000
    } t_state;

    // Undo the palette ordering: swap bits 3 and 4 of an 8-bit index
    function automatic logic [7:0] reorder_palette(input logic [7:0] v);
        logic [7:0] r;
        r = {v[7:5], v[3], v[4], v[2:0]};
        return r;
    endfunction

endpackage

// File: rtl/core/texture_unswizzle_addressing.sv
// Write items are stored at the accepting edge.
// Read items pass through the multiply, address add/compare with memory read, and
// output states, and the result is then loaded into the output register.
// Throughput: one write per cycle while no read is in flight; no new item is taken
// while a read is in flight (longer while a held result is stalled at the output).
// Reset clears control state and sets the configuration registers to their
// defaults; the byte store is not cleared and holds garbage until written.
module texture_unswizzle_addressing
    import tua_pkg::*;
#(
    parameter int unsigned STORE_BYTES = STORE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Item input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [15:0] i_write_address,
    input  logic [7:0]  i_write_byte,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,

    // Result output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pixel_index,
    output logic        o_out_of_range,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
    localparam logic [SRC_W-1:0] SRC_LIMIT = SRC_W'(STORE_BYTES);

    // Configuration registers
    logic        r_pixel_mode;
    logic        r_swizzled;
    logic [9:0]  r_half_width;
    logic [10:0] r_image_width;
    logic [10:0] r_image_height;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_mode   <= MODE_8BIT;
            r_swizzled     <= 1'b0;
            r_half_width   <= 10'd1;
            r_image_width  <= 11'd1;
            r_image_height <= 11'd1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PIXEL_MODE:   r_pixel_mode   <= pwdata[0];
                REG_SWIZZLED:     r_swizzled     <= pwdata[0];
                REG_HALF_WIDTH:   r_half_width   <= pwdata[9:0];
                REG_IMAGE_WIDTH:  r_image_width  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: r_image_height <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (cfg_idx)
            REG_PIXEL_MODE:   prdata = {31'd0, r_pixel_mode};
            REG_SWIZZLED:     prdata = {31'd0, r_swizzled};
            REG_HALF_WIDTH:   prdata = {22'd0, r_half_width};
            REG_IMAGE_WIDTH:  prdata = {21'd0, r_image_width};
            REG_IMAGE_HEIGHT: prdata = {21'd0, r_image_height};
            default:          prdata = 32'd0;
        endcase
    end

    // Sequencer
    t_state r_state, n_state;
    logic   in_xfer;
    logic   out_xfer;
    logic   out_load;
    logic   r_out_valid;

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_out_valid && !i_stall;
    assign out_load = (r_state == S_DATA) && (!r_out_valid || !i_stall);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_xfer && i_op == OP_READ) n_state = S_MUL;
            S_MUL:  n_state = S_ADDR;
            S_ADDR: n_state = S_DATA;
            S_DATA: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture read coordinates on transfer
    logic [9:0] r_x, r_y;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_x <= i_pixel_x;
            r_y <= i_pixel_y;
        end
    end

    // Multiply stage: block row offset (or y * width) and swizzle row offset
    logic [10:0] row_w;
    logic [2:0]  sw_row;
    logic [9:0]  mul_a;
    logic [10:0] mul_b;
    logic [20:0] r_prod_a;
    logic [13:0] r_prod_b;
    logic        r_coord_err;

    assign row_w  = {r_half_width, 1'b0};
    assign sw_row = {r_y[3:2], r_y[0]};
    assign mul_a  = r_swizzled ? {r_y[9:4], 4'b0000} : r_y;
    assign mul_b  = r_swizzled ? row_w : r_image_width;

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod_a    <= mul_a * mul_b;
            r_prod_b    <= sw_row * row_w;
            r_coord_err <= ({1'b0, r_x} >= r_image_width) ||
                           ({1'b0, r_y} >= r_image_height);
        end
    end

    // Address stage: source index, byte address, bounds check
    logic [2:0]       sw_col;
    logic [1:0]       sw_lane;
    logic [SRC_W-1:0] src;
    logic [SRC_W-1:0] byte_addr;
    logic             addr_err;
    logic             rd_en;
    logic             r_err;
    logic             r_nib_hi;

    // column select: bit 2 of (y + 2) is y[2] ^ y[1]
    assign sw_col  = {r_x[2] ^ (r_y[2] ^ r_y[1]), r_x[1:0]};
    assign sw_lane = {r_x[3], r_y[1]};

    always_comb begin
        if (r_swizzled) begin
            src = SRC_W'(r_prod_a) + SRC_W'({r_x[9:4], 5'b00000})
                + SRC_W'({r_prod_b, 1'b0}) + SRC_W'({sw_col, 2'b00})
                + SRC_W'(sw_lane);
        end else begin
            src = SRC_W'(r_prod_a) + SRC_W'(r_x);
        end
        byte_addr = (r_pixel_mode == MODE_4BIT) ? (src >> 1) : src;
    end

    assign addr_err = r_coord_err || (byte_addr >= SRC_LIMIT);
    assign rd_en    = (r_state == S_ADDR) && !addr_err;

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADDR) begin
            r_err    <= addr_err;
            r_nib_hi <= src[0];
        end
    end

    // Raw byte store: writes on transfer, reads from the address stage
    logic [7:0]        r_mem [STORE_BYTES];
    logic [7:0]        r_rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;

    assign wr_en   = in_xfer && (i_op == OP_WRITE) &&
                     (32'(i_write_address) < 32'(STORE_BYTES));
    assign wr_addr = ADDR_W'(32'(i_write_address));
    assign rd_addr = byte_addr[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_write_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Output register
    logic [7:0] pix_val;

    always_comb begin
        if (r_err) begin
            pix_val = 8'd0;
        end else if (r_pixel_mode == MODE_4BIT) begin
            pix_val = r_nib_hi ? {4'd0, r_rd_data[7:4]} : {4'd0, r_rd_data[3:0]};
        end else begin
            pix_val = reorder_palette(r_rd_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_pixel_index  <= pix_val;
            o_out_of_range <= r_err;
        end
    end

endmodule

// File: tb/sv/tb_texture_unswizzle_addressing.sv
`timescale 1ns / 1ps

module tb_texture_unswizzle_addressing;
    import tua_pkg::*;

    localparam int unsigned STORE_DEPTH = STORE_BYTES_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_PER_PHASE = 65;
    localparam int unsigned NUM_PHASES = 12;

    // One item on the input channel
    typedef struct packed {
        logic       op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [9:0]  x;
        logic [9:0]  y;
    } t_tex_item;

    // One pixel read result
    typedef struct packed {
        logic [7:0] pixel_index;
        logic       out_of_range;
    } t_pixel_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_op = OP_WRITE;
    logic [15:0] i_write_address = '0;
    logic [7:0]  i_write_byte = '0;
    logic [9:0]  i_pixel_x = '0;
    logic [9:0]  i_pixel_y = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_pixel_index;
    logic        o_out_of_range;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the configuration registers
    logic        cfg_mode = MODE_8BIT;
    logic        cfg_swz = 1'b0;
    int unsigned cfg_half = 1;
    int unsigned cfg_w = 1;
    int unsigned cfg_h = 1;

    // Shadow of the raw byte store, and which entries the stimulus has filled
    logic [7:0]  tex_mem [0:STORE_DEPTH-1];
    bit          written_map [0:STORE_DEPTH-1];

    t_tex_item   texel_req_q [$];
    t_pixel_res  pixel_exp_q [$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_cnt = 0;
    logic [31:0] cycle_cnt = '0;
    logic        in_took = 1'b0;

    texture_unswizzle_addressing #(
        .STORE_BYTES(STORE_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_write_address(i_write_address),
        .i_write_byte   (i_write_byte),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_index  (o_pixel_index),
        .o_out_of_range (o_out_of_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 32'd1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned exp_v,
                                   input int unsigned act_v);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch: %s expected 0x%0h got 0x%0h", what, exp_v, act_v);
    endtask

    // Block / column / byte-interleave address over a row width of w
    function automatic int unsigned swizzle_src(input int unsigned x, input int unsigned y,
                                                input int unsigned w);
        int unsigned blk, sel, row, col, lane;
        blk  = (y & ~32'hF) * w + (x & ~32'hF) * 2;
        sel  = (((y + 2) >> 2) & 1) * 4;
        row  = (((y & ~32'h3) >> 1) + (y & 1)) & 7;
        col  = row * w * 2 + ((x + sel) & 7) * 4;
        lane = ((y >> 1) & 1) + ((x >> 2) & 2);
        return blk + col + lane;
    endfunction

    // Byte address holding pixel (x,y); 0 when the pixel or byte is out of bounds
    function automatic bit locate_byte(input int unsigned x, input int unsigned y,
                                       output int unsigned baddr, output bit hi);
        int unsigned src;
        baddr = 0;
        hi = 1'b0;
        if (x >= cfg_w || y >= cfg_h)
            return 1'b0;
        if (cfg_swz)
            src = swizzle_src(x, y, cfg_half * 2);
        else
            src = y * cfg_w + x;
        hi = src[0];
        baddr = (cfg_mode == MODE_4BIT) ? (src >> 1) : src;
        return baddr < STORE_DEPTH;
    endfunction

    // Apply one accepted transfer: store a byte or queue the expected pixel
    task automatic model_item(input logic op, input logic [15:0] a, input logic [7:0] d,
                              input logic [9:0] x, input logic [9:0] y);
        int unsigned b;
        bit          hi;
        logic [7:0]  v;
        t_pixel_res  r;
        if (op == OP_WRITE) begin
            tex_mem[a] = d;
        end else begin
            r.pixel_index = 8'h00;
            r.out_of_range = 1'b1;
            if (locate_byte(32'(x), 32'(y), b, hi)) begin
                v = tex_mem[b];
                if (cfg_mode == MODE_4BIT) begin
                    v = hi ? {4'h0, v[7:4]} : {4'h0, v[3:0]};
                end else begin
                    // palette order: bits 3 and 4 trade places
                    v[3] = tex_mem[b][4];
                    v[4] = tex_mem[b][3];
                end
                r.pixel_index = v;
                r.out_of_range = 1'b0;
            end
            pixel_exp_q = {pixel_exp_q, r};
        end
    endtask

    // Monitor: record input transfers and check result transfers
    always @(posedge i_clk) begin
        t_pixel_res e;
        in_took <= i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (pixel_exp_q.size() == 0) begin
                    report_mismatch("unexpected result, index",
                                    0, 32'(o_pixel_index));
                end else begin
                    e = pixel_exp_q.pop_front();
                    if (o_pixel_index !== e.pixel_index)
                        report_mismatch("pixel_index", 32'(e.pixel_index),
                                        32'(o_pixel_index));
                    if (o_out_of_range !== e.out_of_range)
                        report_mismatch("out_of_range", 32'(e.out_of_range),
                                        32'(o_out_of_range));
                end
            end
            if (i_valid && !o_stall)
                model_item(i_op, i_write_address, i_write_byte, i_pixel_x, i_pixel_y);
        end
    end

    // Driver: next item once the current one has been taken
    always @(negedge i_clk) begin
        t_tex_item it;
        if (!i_valid || in_took) begin
            if (i_rst_n && texel_req_q.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                it = texel_req_q.pop_front();
                i_op <= it.op;
                i_write_address <= it.addr;
                i_write_byte <= it.data;
                i_pixel_x <= it.x;
                i_pixel_y <= it.y;
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Register write followed by a read-back
    task automatic cfg_write(input logic [2:0] idx, input int unsigned val);
        logic [31:0] mask;
        case (idx)
            REG_PIXEL_MODE, REG_SWIZZLED: mask = 32'h1;
            REG_HALF_WIDTH: mask = 32'h3FF;
            default: mask = 32'h7FF;
        endcase
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== (val & mask))
            report_mismatch($sformatf("register %0d read-back", idx), val & mask, prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PIXEL_MODE: cfg_mode = val[0];
            REG_SWIZZLED: cfg_swz = val[0];
            REG_HALF_WIDTH: cfg_half = val & mask;
            REG_IMAGE_WIDTH: cfg_w = val & mask;
            default: cfg_h = val & mask;
        endcase
    endtask

    task automatic set_config(input logic mode, input logic swz, input int unsigned half,
                              input int unsigned w, input int unsigned h);
        cfg_write(REG_PIXEL_MODE, 32'(mode));
        cfg_write(REG_SWIZZLED, 32'(swz));
        cfg_write(REG_HALF_WIDTH, half);
        cfg_write(REG_IMAGE_WIDTH, w);
        cfg_write(REG_IMAGE_HEIGHT, h);
    endtask

    task automatic gen_write(input int unsigned a, input int unsigned d);
        t_tex_item it;
        it.op = OP_WRITE;
        it.addr = 16'(a);
        it.data = 8'(d);
        it.x = 10'($urandom_range(1023));
        it.y = 10'($urandom_range(1023));
        written_map[a[15:0]] = 1'b1;
        texel_req_q = {texel_req_q, it};
    endtask

    // A read never touches a byte that was never stored: fill it first
    task automatic gen_read(input int unsigned x, input int unsigned y);
        int unsigned b;
        bit          hi;
        t_tex_item   it;
        if (locate_byte(x, y, b, hi) && !written_map[b])
            gen_write(b, $urandom_range(255));
        it.op = OP_READ;
        it.addr = 16'($urandom_range(65535));
        it.data = 8'($urandom_range(255));
        it.x = 10'(x);
        it.y = 10'(y);
        texel_req_q = {texel_req_q, it};
    endtask

    // Coordinate below lim, biased toward the edges and small values
    function automatic int unsigned pick_coord(input int unsigned lim);
        case ($urandom_range(9))
            0: return 0;
            1: return lim - 1;
            2, 3: return $urandom_range(((lim < 32) ? lim : 32) - 1);
            default: return $urandom_range(lim - 1);
        endcase
    endfunction

    task automatic gen_random(input int unsigned n);
        int unsigned roll, x, y, b;
        bit          hi;
        for (int unsigned i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                if (cfg_w != 0 && cfg_h != 0 && roll < 20) begin
                    x = pick_coord(cfg_w);
                    y = pick_coord(cfg_h);
                    if (locate_byte(x, y, b, hi))
                        gen_write(b, $urandom_range(255));
                    else
                        gen_write($urandom_range(65535), $urandom_range(255));
                end else begin
                    gen_write($urandom_range(65535), $urandom_range(255));
                end
            end else if (roll < 88 && cfg_w != 0 && cfg_h != 0) begin
                gen_read(pick_coord(cfg_w), pick_coord(cfg_h));
            end else begin
                gen_read($urandom_range(1023), $urandom_range(1023));
            end
        end
    endtask

    task automatic drain;
        while (texel_req_q.size() != 0 || i_valid || pixel_exp_q.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = (p < 4) ? 9 : (p < 8) ? 57 : 0;
            recv_stall_pct = (p < 4) ? 57 : (p < 8) ? 9 : 0;
            case (p)
                0: begin
                    // reset configuration: a 1x1 image, 8-bit indices
                    gen_write(0, 32'h08);
                    gen_read(0, 0);
                    gen_read(1, 0);
                    gen_read(0, 1);
                    gen_read(1023, 1023);
                    gen_write(32'hFFFF, 32'hFF);
                end
                1: begin
                    // full-size linear image: last byte of the store, then past it
                    set_config(MODE_8BIT, 1'b0, 512, 1024, 1024);
                    gen_read(1023, 63);
                    gen_read(0, 64);
                    gen_write(5, 32'h10);
                    gen_read(5, 0);
                    gen_write(6, 32'h18);
                    gen_read(6, 0);
                    gen_write(7, 32'hE7);
                    gen_read(7, 0);
                end
                2: begin
                    // 4-bit swizzled, both nibbles and a far corner
                    set_config(MODE_4BIT, 1'b1, 512, 1024, 1024);
                    gen_write(0, 32'hA5);
                    gen_read(0, 0);
                    gen_read(1, 0);
                    gen_read(1023, 1023);
                end
                3: begin
                    // zero half width, columns run past the swizzled row
                    set_config(MODE_8BIT, 1'b1, 0, 64, 64);
                    gen_read(63, 63);
                    gen_read(0, 0);
                end
                4: begin
                    set_config(MODE_4BIT, 1'b0, 1, 0, 5);
                    gen_read(0, 0);
                end
                5: begin
                    set_config(MODE_8BIT, 1'b0, 1, 7, 0);
                    gen_read(0, 0);
                end
                default: begin
                    set_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                               $urandom_range(1, 512),
                               ($urandom_range(3) == 0) ? $urandom_range(1, 1024)
                                                        : $urandom_range(1, 96),
                               ($urandom_range(3) == 0) ? $urandom_range(1, 1024)
                                                        : $urandom_range(1, 96));
                end
            endcase
            gen_random(RANDOM_PER_PHASE);
            // hold the sender until every pixel has come back
            drain;
            repeat (8) @(negedge i_clk);
        end

        drain;
        repeat (10) @(negedge i_clk);
        if (pixel_exp_q.size() != 0) begin
            err_cnt += pixel_exp_q.size();
            $display("%0d pixel results never arrived", pixel_exp_q.size());
        end
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
